FILE: rtl/avg_pkg.sv
// ----------------------------------------------------------------------------
// avg_pkg
// Shared widths, constants, register codes and stage structs for the
// arrowhead vertex generator.
// ----------------------------------------------------------------------------
package avg_pkg;

    // coordinate saturation range
    localparam int COORD_BITS = 16;
    localparam longint SAT_HI = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    // field and datapath widths
    localparam int FIELD_W = 16;
    localparam int DIFF_W  = 17;
    localparam int SQ_W    = 32;
    localparam int RAD_W   = 49;
    localparam int MAG_W   = 25;
    localparam int PROD_W  = 34;
    localparam int ABS_W   = 32;
    localparam int LEN_W   = 8;
    localparam int NUM_W   = 41;
    localparam int QUO_W   = 17;
    localparam int POS_W   = 18;
    localparam int LANES   = 8;
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 32;

    // rotation constants, Q1.15
    localparam logic signed [DIFF_W-1:0] ROT_C [4] = '{
        17'sd28378,   // cos 30
        17'sd16384,   // sin 30
        17'sd31651,   // cos 15
        17'sd8481     // sin 15
    };

    // product slots: dx times the four constants, then dy
    localparam int P_XC30 = 0;
    localparam int P_XS30 = 1;
    localparam int P_XC15 = 2;
    localparam int P_XS15 = 3;
    localparam int P_YC30 = 4;
    localparam int P_YS30 = 5;
    localparam int P_YC15 = 6;
    localparam int P_YS15 = 7;

    // vertex lanes
    localparam int LN_OLX = 0;
    localparam int LN_OLY = 1;
    localparam int LN_ILX = 2;
    localparam int LN_ILY = 3;
    localparam int LN_ORX = 4;
    localparam int LN_ORY = 5;
    localparam int LN_IRX = 6;
    localparam int LN_IRY = 7;

    // pen width codes with shortened heads
    localparam logic [7:0] PEN_NARROW = 8'd1;
    localparam logic [7:0] PEN_DOUBLE = 8'd2;

    // register map index
    typedef enum logic [2:0] {
        CFG_HEAD_LENGTH   = 3'd0,
        CFG_CANVAS_LEFT   = 3'd1,
        CFG_CANVAS_TOP    = 3'd2,
        CFG_CANVAS_RIGHT  = 3'd3,
        CFG_CANVAS_BOTTOM = 3'd4
    } t_cfg_idx;

    // segment geometry carried through the root pipeline
    typedef struct packed {
        logic signed [FIELD_W-1:0] tx;
        logic signed [FIELD_W-1:0] ty;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic [LEN_W-1:0]          lo;
        logic signed [LEN_W:0]     li;
        logic                      deg;
    } t_geo;

    // tip and flag carried through the divider
    typedef struct packed {
        logic signed [FIELD_W-1:0] tx;
        logic signed [FIELD_W-1:0] ty;
        logic                      deg;
    } t_dside;

    // one finished result word
    typedef struct packed {
        logic [FIELD_W-1:0]            tip_x;
        logic [FIELD_W-1:0]            tip_y;
        logic [LANES-1:0][FIELD_W-1:0] vtx;
        logic                          deg;
    } t_res;

    // saturate to the coordinate range, then place in a 16 bit field
    function automatic logic [FIELD_W-1:0] sat_coord(input logic signed [POS_W-1:0] v);
        logic [FIELD_W-1:0] r;
        if (longint'(v) > SAT_HI) begin
            r = FIELD_W'(SAT_HI);
        end else if (longint'(v) < SAT_LO) begin
            r = FIELD_W'(SAT_LO);
        end else begin
            r = FIELD_W'(v);
        end
        return r;
    endfunction

endpackage

FILE: rtl/avg_isqrt.sv
// ----------------------------------------------------------------------------
// avg_isqrt
// Pipelined integer square root, one root bit per stage, with the segment
// geometry riding alongside.
// ----------------------------------------------------------------------------
module avg_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [avg_pkg::RAD_W-1:0]  i_rad,
    input  avg_pkg::t_geo              i_geo,
    output logic                       o_valid,
    output logic [avg_pkg::MAG_W-1:0]  o_root,
    output avg_pkg::t_geo              o_geo
);

    localparam int NS  = avg_pkg::MAG_W;
    localparam int RW  = avg_pkg::RAD_W;
    localparam int TW  = avg_pkg::RAD_W + 2;

    logic             r_vld  [NS];
    logic [RW-1:0]    r_rem  [NS];
    logic [NS-1:0]    r_root [NS];
    avg_pkg::t_geo    r_geo  [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int K = NS - 1 - j;

        logic          v_in;
        logic [RW-1:0] rem_in;
        logic [NS-1:0] root_in;
        avg_pkg::t_geo geo_in;
        logic [TW-1:0] trial;
        logic          fit;
        logic [RW-1:0] n_rem;
        logic [NS-1:0] n_root;

        // stage input comes from the port or the stage before
        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_rad;
            assign root_in = '0;
            assign geo_in  = i_geo;
        end else begin : g_next
            assign v_in    = r_vld[j-1];
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign geo_in  = r_geo[j-1];
        end

        // try setting root bit K: (root + 2^K)^2 - root^2
        assign trial  = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
        assign fit    = {2'b00, rem_in} >= trial;
        assign n_rem  = fit ? (rem_in - trial[RW-1:0]) : rem_in;
        assign n_root = fit ? (root_in | (NS'(1) << K)) : root_in;

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= v_in;
            end
        end

        // stage payload
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
                r_geo[j]  <= geo_in;
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_geo   = r_geo[NS-1];

endmodule

FILE: rtl/avg_div.sv
// ----------------------------------------------------------------------------
// avg_div
// Eight-lane pipelined restoring divider, one quotient bit per stage, all
// lanes sharing one divisor.
// ----------------------------------------------------------------------------
module avg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [avg_pkg::NUM_W-1:0]     i_num [avg_pkg::LANES],
    input  logic [avg_pkg::LANES-1:0]     i_neg,
    input  logic [avg_pkg::MAG_W-1:0]     i_mag,
    input  avg_pkg::t_dside               i_side,
    output logic                          o_valid,
    output logic [avg_pkg::QUO_W-1:0]     o_quo [avg_pkg::LANES],
    output logic [avg_pkg::LANES-1:0]     o_neg,
    output avg_pkg::t_dside               o_side
);

    localparam int NS = avg_pkg::QUO_W;
    localparam int NL = avg_pkg::LANES;
    localparam int NW = avg_pkg::NUM_W;
    localparam int MW = avg_pkg::MAG_W;

    logic             r_vld  [NS];
    logic [NW-1:0]    r_rem  [NS][NL];
    logic [NS-1:0]    r_quo  [NS][NL];
    logic [NL-1:0]    r_neg  [NS];
    logic [MW-1:0]    r_mag  [NS];
    avg_pkg::t_dside  r_side [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int K = NS - 1 - j;

        logic            v_in;
        logic [NL-1:0]   neg_in;
        logic [MW-1:0]   mag_in;
        avg_pkg::t_dside side_in;
        logic [NW-1:0]   dsh;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign neg_in  = i_neg;
            assign mag_in  = i_mag;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_vld[j-1];
            assign neg_in  = r_neg[j-1];
            assign mag_in  = r_mag[j-1];
            assign side_in = r_side[j-1];
        end

        // divisor aligned to quotient bit K
        assign dsh = NW'(mag_in) << K;

        // stage valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= v_in;
            end
        end

        // shared sideband
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[j]  <= neg_in;
                r_mag[j]  <= mag_in;
                r_side[j] <= side_in;
            end
        end

        for (genvar l = 0; l < NL; l++) begin : g_lane
            logic [NW-1:0] rem_in;
            logic [NS-1:0] quo_in;
            logic          fit;

            if (j == 0) begin : g_first
                assign rem_in = i_num[l];
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[j-1][l];
                assign quo_in = r_quo[j-1][l];
            end

            // compare and subtract
            assign fit = rem_in >= dsh;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j][l] <= fit ? (rem_in - dsh) : rem_in;
                    r_quo[j][l] <= fit ? (quo_in | (NS'(1) << K)) : quo_in;
                end
            end
        end
    end

    // last stage drives the outputs
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            o_quo[l] = r_quo[NS-1][l];
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_neg   = r_neg[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

FILE: rtl/arrowhead_vertex_generator_unit.sv
// throughput: one word per cycle while the skid register is empty; the 25-stage root
//   and 17-stage divider pipelines each take a new segment every cycle that they advance
// a stalled output parks one word in a skid register before the input stalls
// reset (synchronous, active low) empties the pipeline and loads the registers
//   with head length 40 and canvas 0,0 to 4095,4095
// ----------------------------------------------------------------------------
// arrowhead_vertex_generator_unit
// Clamps the tip, finds the segment length, rotates and scales the direction
// to four arrowhead vertices. APB-style register port.
// ----------------------------------------------------------------------------
module arrowhead_vertex_generator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [avg_pkg::CFG_AW-1:0]         paddr,
    input  logic [avg_pkg::CFG_DW-1:0]         pwdata,
    output logic [avg_pkg::CFG_DW-1:0]         prdata,
    output logic                               pready,
    // input words
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [avg_pkg::FIELD_W-1:0] i_tail_x,
    input  logic signed [avg_pkg::FIELD_W-1:0] i_tail_y,
    input  logic signed [avg_pkg::FIELD_W-1:0] i_tip_x,
    input  logic signed [avg_pkg::FIELD_W-1:0] i_tip_y,
    input  logic [7:0]                         i_pen_width,
    // result words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [avg_pkg::FIELD_W-1:0] o_clamped_tip_x,
    output logic signed [avg_pkg::FIELD_W-1:0] o_clamped_tip_y,
    output logic signed [avg_pkg::FIELD_W-1:0] o_outer_left_x,
    output logic signed [avg_pkg::FIELD_W-1:0] o_outer_left_y,
    output logic signed [avg_pkg::FIELD_W-1:0] o_inner_left_x,
    output logic signed [avg_pkg::FIELD_W-1:0] o_inner_left_y,
    output logic signed [avg_pkg::FIELD_W-1:0] o_outer_right_x,
    output logic signed [avg_pkg::FIELD_W-1:0] o_outer_right_y,
    output logic signed [avg_pkg::FIELD_W-1:0] o_inner_right_x,
    output logic signed [avg_pkg::FIELD_W-1:0] o_inner_right_y,
    output logic                               o_degenerate
);

    localparam int FW = avg_pkg::FIELD_W;
    localparam int NL = avg_pkg::LANES;

    // configuration registers
    logic [7:0]           r_head_length;
    logic signed [FW-1:0] r_canvas_left;
    logic signed [FW-1:0] r_canvas_top;
    logic signed [FW-1:0] r_canvas_right;
    logic signed [FW-1:0] r_canvas_bottom;

    avg_pkg::t_cfg_idx cfg_idx;
    logic              cfg_wr;

    assign cfg_idx = avg_pkg::t_cfg_idx'(paddr[avg_pkg::CFG_AW-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_length   <= 8'd40;
            r_canvas_left   <= '0;
            r_canvas_top    <= '0;
            r_canvas_right  <= 16'sd4095;
            r_canvas_bottom <= 16'sd4095;
        end else if (cfg_wr) begin
            case (cfg_idx)
                avg_pkg::CFG_HEAD_LENGTH:   r_head_length   <= pwdata[7:0];
                avg_pkg::CFG_CANVAS_LEFT:   r_canvas_left   <= pwdata[FW-1:0];
                avg_pkg::CFG_CANVAS_TOP:    r_canvas_top    <= pwdata[FW-1:0];
                avg_pkg::CFG_CANVAS_RIGHT:  r_canvas_right  <= pwdata[FW-1:0];
                avg_pkg::CFG_CANVAS_BOTTOM: r_canvas_bottom <= pwdata[FW-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (cfg_idx)
            avg_pkg::CFG_HEAD_LENGTH:   prdata = {24'd0, r_head_length};
            avg_pkg::CFG_CANVAS_LEFT:   prdata = 32'(r_canvas_left);
            avg_pkg::CFG_CANVAS_TOP:    prdata = 32'(r_canvas_top);
            avg_pkg::CFG_CANVAS_RIGHT:  prdata = 32'(r_canvas_right);
            avg_pkg::CFG_CANVAS_BOTTOM: prdata = 32'(r_canvas_bottom);
            default:                    prdata = '0;
        endcase
    end

    // pipeline advance: stalls only when the skid register is occupied
    logic r_skid_valid;
    logic en;

    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    // ---------------- stage 1: clamp tip, head lengths ----------------
    logic signed [FW-1:0] n_s1_tx_lo, n_s1_tx, n_s1_ty_lo, n_s1_ty;
    logic [18:0]          n_s1_two3;
    logic [7:0]           n_s1_third;
    logic [6:0]           n_s1_half;
    logic [7:0]           n_s1_lo;
    logic signed [8:0]    n_s1_li;

    // raise to left/top, then lower to right/bottom
    assign n_s1_tx_lo = (i_tip_x < r_canvas_left) ? r_canvas_left : i_tip_x;
    assign n_s1_tx    = (n_s1_tx_lo > r_canvas_right) ? r_canvas_right : n_s1_tx_lo;
    assign n_s1_ty_lo = (i_tip_y < r_canvas_top) ? r_canvas_top : i_tip_y;
    assign n_s1_ty    = (n_s1_ty_lo > r_canvas_bottom) ? r_canvas_bottom : n_s1_ty_lo;

    // floor(2h/3) by reciprocal multiply, exact for 2h below 2048
    assign n_s1_two3  = 19'({r_head_length, 1'b0}) * 19'd683;
    assign n_s1_third = n_s1_two3[18:11];
    assign n_s1_half  = r_head_length[7:1];

    // outer and inner lengths per pen width
    always_comb begin
        n_s1_lo = r_head_length;
        n_s1_li = $signed({1'b0, r_head_length}) - 9'sd3;
        case (i_pen_width)
            avg_pkg::PEN_NARROW: begin
                n_s1_lo = {1'b0, n_s1_half};
                if (n_s1_half >= 7'd2) begin
                    n_s1_li = $signed({2'b00, n_s1_half}) - 9'sd2;
                end else if (n_s1_half == 7'd1) begin
                    n_s1_li = '0;
                end else begin
                    n_s1_li = -9'sd1;
                end
            end
            avg_pkg::PEN_DOUBLE: begin
                n_s1_lo = n_s1_third + 8'd2;
                n_s1_li = $signed({1'b0, n_s1_third});
            end
            default: ;
        endcase
    end

    logic                 r_s1_vld;
    logic signed [FW-1:0] r_s1_ax, r_s1_ay, r_s1_tx, r_s1_ty;
    logic [7:0]           r_s1_lo;
    logic signed [8:0]    r_s1_li;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ax <= i_tail_x;
            r_s1_ay <= i_tail_y;
            r_s1_tx <= n_s1_tx;
            r_s1_ty <= n_s1_ty;
            r_s1_lo <= n_s1_lo;
            r_s1_li <= n_s1_li;
        end
    end

    // ---------------- stage 2: direction vector ----------------
    avg_pkg::t_geo n_s2_geo;

    always_comb begin
        n_s2_geo.tx  = r_s1_tx;
        n_s2_geo.ty  = r_s1_ty;
        n_s2_geo.dx  = 17'(r_s1_ax) - 17'(r_s1_tx);
        n_s2_geo.dy  = 17'(r_s1_ay) - 17'(r_s1_ty);
        n_s2_geo.lo  = r_s1_lo;
        n_s2_geo.li  = r_s1_li;
        n_s2_geo.deg = (r_s1_ax == r_s1_tx) && (r_s1_ay == r_s1_ty);
    end

    logic          r_s2_vld;
    avg_pkg::t_geo r_s2_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_geo <= n_s2_geo;
        end
    end

    // ---------------- stage 3: squares ----------------
    logic signed [2*avg_pkg::DIFF_W-1:0] n_s3_sqx, n_s3_sqy;

    assign n_s3_sqx = r_s2_geo.dx * r_s2_geo.dx;
    assign n_s3_sqy = r_s2_geo.dy * r_s2_geo.dy;

    logic                     r_s3_vld;
    logic [avg_pkg::SQ_W-1:0] r_s3_sqx, r_s3_sqy;
    avg_pkg::t_geo            r_s3_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_sqx <= n_s3_sqx[avg_pkg::SQ_W-1:0];
            r_s3_sqy <= n_s3_sqy[avg_pkg::SQ_W-1:0];
            r_s3_geo <= r_s2_geo;
        end
    end

    // ---------------- stage 4: squared length in Q16 ----------------
    logic [avg_pkg::SQ_W:0]    n_s4_sum;
    logic                      r_s4_vld;
    logic [avg_pkg::RAD_W-1:0] r_s4_rad;
    avg_pkg::t_geo             r_s4_geo;

    assign n_s4_sum = 33'(r_s3_sqx) + 33'(r_s3_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (en) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_rad <= {n_s4_sum, 16'd0};
            r_s4_geo <= r_s3_geo;
        end
    end

    // ---------------- magnitude in Q8 ----------------
    logic                      sq_vld;
    logic [avg_pkg::MAG_W-1:0] sq_mag;
    avg_pkg::t_geo             sq_geo;

    avg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_vld),
        .i_rad   (r_s4_rad),
        .i_geo   (r_s4_geo),
        .o_valid (sq_vld),
        .o_root  (sq_mag),
        .o_geo   (sq_geo)
    );

    // ---------------- R1: rotation products ----------------
    logic signed [avg_pkg::PROD_W-1:0] n_r1_p [NL];

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            if (i < 4) begin
                n_r1_p[i] = sq_geo.dx * avg_pkg::ROT_C[i % 4];
            end else begin
                n_r1_p[i] = sq_geo.dy * avg_pkg::ROT_C[i % 4];
            end
        end
    end

    logic                              r_r1_vld;
    logic signed [avg_pkg::PROD_W-1:0] r_r1_p [NL];
    logic [avg_pkg::MAG_W-1:0]         r_r1_mag;
    avg_pkg::t_geo                     r_r1_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_vld <= 1'b0;
        end else if (en) begin
            r_r1_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r1_p   <= n_r1_p;
            r_r1_mag <= sq_mag;
            r_r1_geo <= sq_geo;
        end
    end

    // ---------------- R2: rotated vectors, sign and magnitude ----------------
    logic signed [avg_pkg::PROD_W-1:0] n_r2_rot [NL];
    logic [avg_pkg::ABS_W-1:0]         n_r2_abs [NL];
    logic [NL-1:0]                     n_r2_neg;

    always_comb begin
        n_r2_rot[avg_pkg::LN_OLX] = r_r1_p[avg_pkg::P_XC30] - r_r1_p[avg_pkg::P_YS30];
        n_r2_rot[avg_pkg::LN_OLY] = r_r1_p[avg_pkg::P_XS30] + r_r1_p[avg_pkg::P_YC30];
        n_r2_rot[avg_pkg::LN_ILX] = r_r1_p[avg_pkg::P_XC15] - r_r1_p[avg_pkg::P_YS15];
        n_r2_rot[avg_pkg::LN_ILY] = r_r1_p[avg_pkg::P_XS15] + r_r1_p[avg_pkg::P_YC15];
        n_r2_rot[avg_pkg::LN_ORX] = r_r1_p[avg_pkg::P_XC30] + r_r1_p[avg_pkg::P_YS30];
        n_r2_rot[avg_pkg::LN_ORY] = r_r1_p[avg_pkg::P_YC30] - r_r1_p[avg_pkg::P_XS30];
        n_r2_rot[avg_pkg::LN_IRX] = r_r1_p[avg_pkg::P_XC15] + r_r1_p[avg_pkg::P_YS15];
        n_r2_rot[avg_pkg::LN_IRY] = r_r1_p[avg_pkg::P_YC15] - r_r1_p[avg_pkg::P_XS15];
        for (int l = 0; l < NL; l++) begin
            n_r2_neg[l] = n_r2_rot[l][avg_pkg::PROD_W-1];
            n_r2_abs[l] = n_r2_neg[l] ? avg_pkg::ABS_W'(-n_r2_rot[l])
                                      : avg_pkg::ABS_W'(n_r2_rot[l]);
        end
    end

    logic                      r_r2_vld;
    logic [avg_pkg::ABS_W-1:0] r_r2_abs [NL];
    logic [NL-1:0]             r_r2_neg;
    logic [avg_pkg::MAG_W-1:0] r_r2_mag;
    avg_pkg::t_geo             r_r2_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r2_vld <= 1'b0;
        end else if (en) begin
            r_r2_vld <= r_r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r2_abs <= n_r2_abs;
            r_r2_neg <= n_r2_neg;
            r_r2_mag <= r_r1_mag;
            r_r2_geo <= r_r1_geo;
        end
    end

    // ---------------- R3: scale by head length, doubled ----------------
    logic                      n_r3_li_neg;
    logic [7:0]                n_r3_li_mag;
    logic [39:0]               n_r3_prod [NL];
    logic [avg_pkg::NUM_W-1:0] n_r3_num [NL];
    logic [NL-1:0]             n_r3_neg;
    avg_pkg::t_dside           n_r3_side;

    assign n_r3_li_neg = r_r2_geo.li[8];
    assign n_r3_li_mag = n_r3_li_neg ? 8'(-r_r2_geo.li) : r_r2_geo.li[7:0];

    // inner lanes are those with lane bit 1 set
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            if ((l & 2) != 0) begin
                n_r3_prod[l] = 40'(r_r2_abs[l]) * 40'(n_r3_li_mag);
                n_r3_neg[l]  = r_r2_neg[l] ^ n_r3_li_neg;
            end else begin
                n_r3_prod[l] = 40'(r_r2_abs[l]) * 40'(r_r2_geo.lo);
                n_r3_neg[l]  = r_r2_neg[l];
            end
            n_r3_num[l] = {n_r3_prod[l], 1'b0};
        end
        n_r3_side.tx  = r_r2_geo.tx;
        n_r3_side.ty  = r_r2_geo.ty;
        n_r3_side.deg = r_r2_geo.deg;
    end

    logic                      r_r3_vld;
    logic [avg_pkg::NUM_W-1:0] r_r3_num [NL];
    logic [NL-1:0]             r_r3_neg;
    logic [avg_pkg::MAG_W-1:0] r_r3_mag;
    avg_pkg::t_dside           r_r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r3_vld <= 1'b0;
        end else if (en) begin
            r_r3_vld <= r_r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r3_num  <= n_r3_num;
            r_r3_neg  <= n_r3_neg;
            r_r3_mag  <= r_r2_mag;
            r_r3_side <= n_r3_side;
        end
    end

    // ---------------- offsets: scaled vector over magnitude ----------------
    logic                      dv_vld;
    logic [avg_pkg::QUO_W-1:0] dv_quo [NL];
    logic [NL-1:0]             dv_neg;
    avg_pkg::t_dside           dv_side;

    avg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_r3_vld),
        .i_num   (r_r3_num),
        .i_neg   (r_r3_neg),
        .i_mag   (r_r3_mag),
        .i_side  (r_r3_side),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_neg   (dv_neg),
        .o_side  (dv_side)
    );

    // ---------------- V1: add to tip, drop fraction toward zero ----------------
    logic signed [avg_pkg::POS_W-1:0] n_v1_off [NL];
    logic signed [25:0]               n_v1_sum [NL];
    logic signed [25:0]               n_v1_adj [NL];
    logic signed [avg_pkg::POS_W-1:0] n_v1_pos [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n_v1_off[l] = dv_neg[l] ? -$signed({1'b0, dv_quo[l]}) : $signed({1'b0, dv_quo[l]});
            if ((l & 1) == 0) begin
                n_v1_sum[l] = $signed({{2{dv_side.tx[FW-1]}}, dv_side.tx, 8'd0})
                            + 26'(n_v1_off[l]);
            end else begin
                n_v1_sum[l] = $signed({{2{dv_side.ty[FW-1]}}, dv_side.ty, 8'd0})
                            + 26'(n_v1_off[l]);
            end
            n_v1_adj[l] = n_v1_sum[l][25] ? (n_v1_sum[l] + 26'sd255) : n_v1_sum[l];
            n_v1_pos[l] = avg_pkg::POS_W'(n_v1_adj[l] >>> 8);
        end
    end

    logic                             r_v1_vld;
    logic signed [avg_pkg::POS_W-1:0] r_v1_pos [NL];
    avg_pkg::t_dside                  r_v1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1_vld <= 1'b0;
        end else if (en) begin
            r_v1_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v1_pos  <= n_v1_pos;
            r_v1_side <= dv_side;
        end
    end

    // ---------------- result word: saturate, degenerate select ----------------
    avg_pkg::t_res n_res;
    logic          push;

    assign push = en & r_v1_vld;

    always_comb begin
        n_res.tip_x = avg_pkg::sat_coord(avg_pkg::POS_W'(r_v1_side.tx));
        n_res.tip_y = avg_pkg::sat_coord(avg_pkg::POS_W'(r_v1_side.ty));
        n_res.deg   = r_v1_side.deg;
        for (int l = 0; l < NL; l++) begin
            if (r_v1_side.deg) begin
                n_res.vtx[l] = ((l & 1) == 0) ? n_res.tip_x : n_res.tip_y;
            end else begin
                n_res.vtx[l] = avg_pkg::sat_coord(r_v1_pos[l]);
            end
        end
    end

    // ---------------- output register and skid ----------------
    logic          r_out_valid;
    avg_pkg::t_res r_out;
    avg_pkg::t_res r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid  <= r_skid_valid | push;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (push) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_clamped_tip_x = r_out.tip_x;
    assign o_clamped_tip_y = r_out.tip_y;
    assign o_outer_left_x  = r_out.vtx[avg_pkg::LN_OLX];
    assign o_outer_left_y  = r_out.vtx[avg_pkg::LN_OLY];
    assign o_inner_left_x  = r_out.vtx[avg_pkg::LN_ILX];
    assign o_inner_left_y  = r_out.vtx[avg_pkg::LN_ILY];
    assign o_outer_right_x = r_out.vtx[avg_pkg::LN_ORX];
    assign o_outer_right_y = r_out.vtx[avg_pkg::LN_ORY];
    assign o_inner_right_x = r_out.vtx[avg_pkg::LN_IRX];
    assign o_inner_right_y = r_out.vtx[avg_pkg::LN_IRY];
    assign o_degenerate    = r_out.deg;

endmodule

FILE: rtl/avg_checker.sv
// ----------------------------------------------------------------------------
// avg_checker
// Port-level checks on the arrowhead vertex generator output side.
// ----------------------------------------------------------------------------
module avg_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [avg_pkg::FIELD_W-1:0] o_clamped_tip_x,
    input logic signed [avg_pkg::FIELD_W-1:0] o_clamped_tip_y,
    input logic signed [avg_pkg::FIELD_W-1:0] o_outer_left_x,
    input logic signed [avg_pkg::FIELD_W-1:0] o_outer_left_y,
    input logic signed [avg_pkg::FIELD_W-1:0] o_inner_left_x,
    input logic signed [avg_pkg::FIELD_W-1:0] o_inner_left_y,
    input logic signed [avg_pkg::FIELD_W-1:0] o_outer_right_x,
    input logic signed [avg_pkg::FIELD_W-1:0] o_outer_right_y,
    input logic signed [avg_pkg::FIELD_W-1:0] o_inner_right_x,
    input logic signed [avg_pkg::FIELD_W-1:0] o_inner_right_y,
    input logic                               o_degenerate
);

    // reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // input only stalls while a word is parked behind the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // parked word stays parked while the output is blocked
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && !i_out_ready |=> !o_in_ready)
        else $error("skid word lost under stall");

    // no direction: every vertex sits on the tip
    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |->
            o_outer_left_x == o_clamped_tip_x && o_outer_left_y == o_clamped_tip_y &&
            o_inner_left_x == o_clamped_tip_x && o_inner_left_y == o_clamped_tip_y &&
            o_outer_right_x == o_clamped_tip_x && o_outer_right_y == o_clamped_tip_y &&
            o_inner_right_x == o_clamped_tip_x && o_inner_right_y == o_clamped_tip_y)
        else $error("degenerate word with vertex off the tip");

    // blocked word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_outer_left_x) && $stable(o_clamped_tip_y))
        else $error("output word changed while stalled");

endmodule

bind arrowhead_vertex_generator_unit avg_checker u_avg_checker (.*);

FILE: tb/sv/arrowhead_vertex_generator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrowhead_vertex_generator_unit_test
// Drives segments through the vertex generator under random handshake
// pressure and checks every result word against an in-bench fixed-point
// predictor, across several canvas and head-length settings.
// ----------------------------------------------------------------------------
module arrowhead_vertex_generator_unit_test;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 70;

    // one predicted result word
    typedef struct {
        logic signed [15:0] crd [10];
        logic               deg;
    } t_arrow_word;

    // predictor and store of pending arrowheads
    class t_arrow_scoreboard;
        t_arrow_word pending [$];
        longint      head_len;
        longint      edge_l, edge_t, edge_r, edge_b;
        int          errors;

        function void restore();
            head_len = 40; edge_l = 0; edge_t = 0; edge_r = 4095; edge_b = 4095;
        endfunction

        function void write_reg(avg_pkg::t_cfg_idx idx, logic [15:0] val);
            case (idx)
                avg_pkg::CFG_HEAD_LENGTH:   head_len = val[7:0];
                avg_pkg::CFG_CANVAS_LEFT:   edge_l = longint'(signed'(val));
                avg_pkg::CFG_CANVAS_TOP:    edge_t = longint'(signed'(val));
                avg_pkg::CFG_CANVAS_RIGHT:  edge_r = longint'(signed'(val));
                avg_pkg::CFG_CANVAS_BOTTOM: edge_b = longint'(signed'(val));
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            longint r;
            r = v;
            if (r < lo) r = lo;
            if (r > hi) r = hi;
            return r;
        endfunction

        function longint unsigned isqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function logic signed [15:0] sat(longint v);
            if (v > avg_pkg::SAT_HI) return 16'sh7fff;
            if (v < avg_pkg::SAT_LO) return 16'sh8000;
            return v[15:0];
        endfunction

        function logic signed [15:0] place(longint tip, longint rot, longint len,
                                           longint mag);
            longint off;
            off = (rot * len * 2) / mag;
            return sat((tip * 256 + off) / 256);
        endfunction

        // work out the arrowhead for one accepted segment
        function void note_segment(logic signed [15:0] ax, logic signed [15:0] ay,
                                   logic signed [15:0] bx, logic signed [15:0] by,
                                   logic [7:0] pen);
            t_arrow_word w;
            longint tx, ty, dx, dy, lo, li, mag;
            tx = clamp(bx, edge_l, edge_r);
            ty = clamp(by, edge_t, edge_b);
            if (pen == avg_pkg::PEN_NARROW) begin
                lo = head_len / 2;
                li = (lo >= 2) ? lo - 2 : (lo == 1 ? 0 : -1);
            end else if (pen == avg_pkg::PEN_DOUBLE) begin
                lo = head_len * 2 / 3 + 2;
                li = lo - 2;
            end else begin
                lo = head_len;
                li = head_len - 3;
            end
            dx = longint'(ax) - tx;
            dy = longint'(ay) - ty;
            w.crd[0] = sat(tx);
            w.crd[1] = sat(ty);
            if (dx == 0 && dy == 0) begin
                for (int k = 2; k < 10; k += 2) begin
                    w.crd[k] = w.crd[0];
                    w.crd[k+1] = w.crd[1];
                end
                w.deg = 1'b1;
            end else begin
                mag = longint'(isqrt(longint'(dx * dx + dy * dy) << 16));
                w.crd[2] = place(tx, dx * 28378 - dy * 16384, lo, mag);
                w.crd[3] = place(ty, dx * 16384 + dy * 28378, lo, mag);
                w.crd[4] = place(tx, dx * 31651 - dy * 8481, li, mag);
                w.crd[5] = place(ty, dx * 8481 + dy * 31651, li, mag);
                w.crd[6] = place(tx, dx * 28378 + dy * 16384, lo, mag);
                w.crd[7] = place(ty, dy * 28378 - dx * 16384, lo, mag);
                w.crd[8] = place(tx, dx * 31651 + dy * 8481, li, mag);
                w.crd[9] = place(ty, dy * 31651 - dx * 8481, li, mag);
                w.deg = 1'b0;
            end
            pending.insert(pending.size(), w);
        endfunction

        // compare one result word with the oldest prediction
        function void check_word(t_arrow_word got);
            t_arrow_word exp_w;
            string names [10] = '{"clamped_tip_x", "clamped_tip_y", "outer_left_x",
                "outer_left_y", "inner_left_x", "inner_left_y", "outer_right_x",
                "outer_right_y", "inner_right_x", "inner_right_y"};
            if (pending.size() == 0) begin
                $error("result word with no prediction pending");
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            for (int k = 0; k < 10; k++) begin
                if (got.crd[k] !== exp_w.crd[k]) begin
                    $error("%s: expected %0d, got %0d", names[k], exp_w.crd[k], got.crd[k]);
                    errors++;
                end
            end
            if (got.deg !== exp_w.deg) begin
                $error("degenerate: expected %0d, got %0d", exp_w.deg, got.deg);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [avg_pkg::CFG_AW-1:0] paddr = '0;
    logic [avg_pkg::CFG_DW-1:0] pwdata = '0;
    logic [avg_pkg::CFG_DW-1:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [15:0] i_tail_x = '0, i_tail_y = '0, i_tip_x = '0, i_tip_y = '0;
    logic [7:0] i_pen_width = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [15:0] o_clamped_tip_x, o_clamped_tip_y;
    logic signed [15:0] o_outer_left_x, o_outer_left_y, o_inner_left_x, o_inner_left_y;
    logic signed [15:0] o_outer_right_x, o_outer_right_y, o_inner_right_x, o_inner_right_y;
    logic o_degenerate;

    t_arrow_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int hold_req = 0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    arrowhead_vertex_generator_unit dut (.*);

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        int hold_left;
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
            i_out_ready <= 1'b0;
            repeat (hold_left) @(posedge i_clk);
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // monitor both channels, watchdog on quiet cycles
    always @(posedge i_clk) begin
        t_arrow_word got;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_segment(i_tail_x, i_tail_y, i_tip_x, i_tip_y, i_pen_width);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.crd = '{o_clamped_tip_x, o_clamped_tip_y, o_outer_left_x, o_outer_left_y,
                        o_inner_left_x, o_inner_left_y, o_outer_right_x, o_outer_right_y,
                        o_inner_right_x, o_inner_right_y};
            got.deg = o_degenerate;
            sb.check_word(got);
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("arrowhead_vertex_generator_unit regression: fail");
            $finish;
        end
    end

    // register write over the APB-style port
    task automatic write_reg(avg_pkg::t_cfg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= avg_pkg::CFG_AW'(4 * int'(idx));
        pwdata <= {{16{val[15]}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic load_config(int hl, int l, int t, int r, int b);
        write_reg(avg_pkg::CFG_HEAD_LENGTH, 16'(hl));
        write_reg(avg_pkg::CFG_CANVAS_LEFT, 16'(l));
        write_reg(avg_pkg::CFG_CANVAS_TOP, 16'(t));
        write_reg(avg_pkg::CFG_CANVAS_RIGHT, 16'(r));
        write_reg(avg_pkg::CFG_CANVAS_BOTTOM, 16'(b));
    endtask

    // offer one segment word and hold it until taken
    task automatic send_segment(int ax, int ay, int bx, int by, int pen);
        i_in_valid <= 1'b1;
        i_tail_x <= 16'(ax); i_tail_y <= 16'(ay);
        i_tip_x <= 16'(bx); i_tip_y <= 16'(by);
        i_pen_width <= 8'(pen);
        do @(posedge i_clk); while (!o_in_ready);
        if ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
    endtask

    task automatic drain();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick(longint a, longint b);
        longint lo, hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        lo = lo - 64; hi = hi + 64;
        if (lo < -32768) lo = -32768;
        if (hi > 32767) hi = 32767;
        return int'(lo + longint'($urandom_range(int'(hi - lo))));
    endfunction

    function automatic int pick_pen();
        case ($urandom_range(5))
            0: return 1;
            1: return 2;
            2: return 0;
            3: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    // random segment: mostly near the canvas, some degenerate, some anywhere
    task automatic random_segment();
        int ax, ay, bx, by, sel;
        sel = $urandom_range(99);
        bx = pick(sb.edge_l, sb.edge_r);
        by = pick(sb.edge_t, sb.edge_b);
        if (sel < 10) begin
            ax = int'(sb.clamp(bx, sb.edge_l, sb.edge_r));
            ay = int'(sb.clamp(by, sb.edge_t, sb.edge_b));
        end else if (sel < 30) begin
            ax = bx + $urandom_range(8) - 4;
            ay = by + $urandom_range(8) - 4;
        end else if (sel < 75) begin
            ax = pick(sb.edge_l, sb.edge_r);
            ay = pick(sb.edge_t, sb.edge_b);
        end else begin
            ax = $urandom_range(65535) - 32768;
            ay = $urandom_range(65535) - 32768;
            bx = $urandom_range(65535) - 32768;
            by = $urandom_range(65535) - 32768;
        end
        send_segment(ax, ay, bx, by, pick_pen());
    endtask

    initial begin
        sb.restore();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, extremes, pen widths, degenerate, clamping
        send_segment(100, 100, 200, 200, 0);
        send_segment(100, 100, 200, 200, 1);
        send_segment(100, 100, 200, 200, 2);
        send_segment(100, 100, 200, 200, 255);
        send_segment(500, 500, 500, 500, 3);
        send_segment(0, 0, -5, -7, 1);
        send_segment(-32768, -32768, 32767, 32767, 0);
        send_segment(32767, 32767, -32768, -32768, 2);
        send_segment(4095, 4095, 9000, 9000, 0);
        send_segment(10, 4000, 10, 4095, 1);
        send_segment(4095, 0, 4000, 0, 0);
        drain();

        // wide canvas, longest head: saturation at the coordinate limits
        load_config(255, -32768, -32768, 32767, 32767);
        send_segment(32700, 32700, 32767, 32767, 0);
        send_segment(-32700, -32700, -32768, -32768, 0);
        send_segment(-32768, 0, 32767, 0, 7);
        send_segment(0, -32768, 0, 32767, 2);
        send_segment(1, 0, 0, 0, 1);
        drain();

        // crossed edges and tiny head lengths for narrow and double pens
        load_config(3, 100, 200, 50, 150);
        send_segment(0, 0, 75, 175, 1);
        send_segment(50, 150, 999, -999, 1);
        drain();
        load_config(0, 0, 0, 4095, 4095);
        send_segment(300, 0, 0, 0, 1);
        send_segment(0, 300, 0, 0, 2);
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: load_config(40, 0, 0, 4095, 4095);
                1: load_config(255, -32768, -32768, 32767, 32767);
                2: load_config(4, -100, -100, 100, 100);
                3: load_config(2, 1000, 1000, 200, 300);
                4: load_config($urandom_range(4, 255), -2000, 500, 2000, 3000);
                5: load_config(1, -32768, -32768, 32767, 32767);
                default: load_config($urandom_range(255), $urandom_range(65535) - 32768,
                                     -500, 32767, $urandom_range(65535) - 32768);
            endcase
            send_idle = (phase < 3) ? 32 : (phase < 5) ? 78 : 0;
            recv_idle = (phase < 3) ? 78 : (phase < 5) ? 32 : 0;
            for (int n = 0; n < 270; n++) begin
                if (phase == 1 && n == 40) hold_req = 400;
                if (phase == 3 && n == 100) drain();
                random_segment();
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("arrowhead_vertex_generator_unit regression: pass");
        end else begin
            $display("arrowhead_vertex_generator_unit regression: fail");
        end
        $finish;
    end
endmodule

FILE: arrowhead_vertex_generator_unit.f
rtl/avg_pkg.sv
rtl/avg_isqrt.sv
rtl/avg_div.sv
rtl/arrowhead_vertex_generator_unit.sv
rtl/avg_checker.sv
tb/sv/arrowhead_vertex_generator_unit_test.sv
